// ----- sv/independent_watchdog_peripheral_defines.svh -----
// Assertion macros shared by the watchdog peripheral RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INDEPENDENT_WATCHDOG_PERIPHERAL_DEFINES_SVH
`define INDEPENDENT_WATCHDOG_PERIPHERAL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IWDP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("watchdog peripheral assertion failed");

// next-cycle implication, disabled during reset
`define IWDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("watchdog peripheral assertion failed");

`endif

// ----- sv/iwdp_pkg.sv -----
// Constants and types for the watchdog peripheral: operation codes,
// register offsets, key values and revision thresholds. No dependencies.
package iwdp_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam int unsigned OFFSET_BITS = 10;
   localparam int unsigned DATA_BITS   = 16;
   localparam int unsigned REV_BITS    = 8;
   localparam int unsigned CODE_BITS   = 4;
   localparam int unsigned PRESC_BITS  = 10;

   localparam logic [OFFSET_BITS-1:0] OFF_KEY     = 10'd0;
   localparam logic [OFFSET_BITS-1:0] OFF_PRESC   = 10'd4;
   localparam logic [OFFSET_BITS-1:0] OFF_RELOAD  = 10'd8;
   localparam logic [OFFSET_BITS-1:0] OFF_STATUS  = 10'd12;
   localparam logic [OFFSET_BITS-1:0] OFF_EARLY   = 10'd20;
   localparam logic [OFFSET_BITS-1:0] OFF_CLEAR   = 10'd24;
   localparam logic [OFFSET_BITS-1:0] OFF_VERSION = 10'h3F4;

   localparam logic [DATA_BITS-1:0] KEY_UNLOCK = 16'h5555;
   localparam logic [DATA_BITS-1:0] KEY_RELOAD = 16'hAAAA;
   localparam logic [DATA_BITS-1:0] KEY_START  = 16'hCCCC;

   localparam logic [REV_BITS-1:0] REV_RUNBIT   = 8'h31;
   localparam logic [REV_BITS-1:0] REV_CLEARREG = 8'h40;
   localparam logic [REV_BITS-1:0] REV_RESET    = 8'h40;

   localparam logic [CODE_BITS-1:0] MAX_CODE = 4'h8;

   localparam int unsigned STATUS_RUN_BIT    = 8;
   localparam int unsigned FLAG_BIT_NEW      = 15;
   localparam int unsigned FLAG_BIT_OLD      = 14;
   localparam int unsigned EARLY_ENABLE_BIT  = 15;
   localparam int unsigned EW_MAX_BITS       = 14;

endpackage

// ----- sv/independent_watchdog_peripheral.sv -----
// Watchdog peripheral with early wakeup interrupt, bus and tick driven.
// Depends on iwdp_pkg and independent_watchdog_peripheral_defines.svh.
//
// Usage:
//   req_*  : one transfer per bus write, bus read or source-clock tick.
//   rsp_*  : one transfer per request: read data, early interrupt level
//            and the reset request pulse of that request.
//   csr_*  : hardware revision register, written when csr_write_enable
//            is high; write it only while no request is in flight.
// A request accepted at one edge has its response valid after that edge.
// Throughput is one request per cycle without a stall, set by the single
// response register; the state update is done in the accept cycle.
// Reset clears the lock, stops the counter, sets counter and reload to all
// ones and the revision to 0x40; no response is pending afterwards.
// When the receiver stalls, the response register holds and req_ready
// drops; a request is still taken in the cycle the response is transferred.
`include "independent_watchdog_peripheral_defines.svh"

module independent_watchdog_peripheral #(
   parameter int unsigned COUNTER_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_operation,
   input  logic [iwdp_pkg::OFFSET_BITS-1:0] req_reg_offset,
   input  logic [iwdp_pkg::DATA_BITS-1:0] req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [iwdp_pkg::DATA_BITS-1:0] rsp_read_data,
   output logic                           rsp_early_irq,
   output logic                           rsp_reset_request,
   input  logic                           csr_write_enable,
   input  logic [iwdp_pkg::REV_BITS-1:0]  csr_write_data
);
   import iwdp_pkg::*;

   localparam int unsigned EW_BITS = (COUNTER_BITS > EW_MAX_BITS) ? EW_MAX_BITS : COUNTER_BITS;

   logic [REV_BITS-1:0]     revision_ff;
   logic [COUNTER_BITS-1:0] down_counter_ff, down_counter_in;
   logic [COUNTER_BITS-1:0] reload_ff, reload_in;
   logic [CODE_BITS-1:0]    prescale_code_ff, prescale_code_in;
   logic [PRESC_BITS-1:0]   prescale_count_ff, prescale_count_in;
   logic [EW_BITS-1:0]      early_compare_ff, early_compare_in;
   logic                    early_enable_ff, early_enable_in;
   logic                    early_flag_ff, early_flag_in;
   logic                    unlocked_ff, unlocked_in;
   logic                    running_ff, running_in;

   logic                    rsp_valid_ff;
   logic [DATA_BITS-1:0]    rsp_read_data_ff, rsp_read_data_in;
   logic                    rsp_early_irq_ff, rsp_early_irq_in;
   logic                    rsp_reset_request_ff, rsp_reset_request_in;

   logic                    req_accept;
   logic                    rev_run, rev_clear;
   logic [CODE_BITS-1:0]    code_clamped;
   logic [PRESC_BITS:0]     divide;
   logic [PRESC_BITS:0]     count_next;
   logic [COUNTER_BITS-1:0] counter_dec;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign rev_run      = revision_ff >= REV_RUNBIT;
   assign rev_clear    = revision_ff >= REV_CLEARREG;
   assign code_clamped = (prescale_code_ff > MAX_CODE) ? MAX_CODE : prescale_code_ff;
   assign divide       = (PRESC_BITS + 1)'(4) << code_clamped;
   assign count_next   = {1'b0, prescale_count_ff} + (PRESC_BITS + 1)'(1);
   assign counter_dec  = down_counter_ff - COUNTER_BITS'(1);

   always_comb begin
      down_counter_in      = down_counter_ff;
      reload_in            = reload_ff;
      prescale_code_in     = prescale_code_ff;
      prescale_count_in    = prescale_count_ff;
      early_compare_in     = early_compare_ff;
      early_enable_in      = early_enable_ff;
      early_flag_in        = early_flag_ff;
      unlocked_in          = unlocked_ff;
      running_in           = running_ff;
      rsp_read_data_in     = '0;
      rsp_reset_request_in = 1'b0;

      case (req_operation)
         OP_WRITE: begin
            case (req_reg_offset)
               OFF_KEY: begin
                  if (req_write_data == KEY_UNLOCK) begin
                     unlocked_in = 1'b1;
                  end else if (req_write_data == KEY_START) begin
                     running_in      = 1'b1;
                     down_counter_in = reload_ff;
                  end else begin
                     if (req_write_data == KEY_RELOAD) begin
                        down_counter_in = reload_ff;
                     end
                     unlocked_in = 1'b0;
                  end
               end
               OFF_PRESC: begin
                  if (unlocked_ff) begin
                     prescale_code_in = req_write_data[CODE_BITS-1:0];
                  end
               end
               OFF_RELOAD: begin
                  if (unlocked_ff) begin
                     reload_in = req_write_data[COUNTER_BITS-1:0];
                  end
               end
               OFF_EARLY: begin
                  if (!rev_clear && req_write_data[FLAG_BIT_OLD]) begin
                     early_flag_in = 1'b0;
                  end
                  if (unlocked_ff) begin
                     early_compare_in = req_write_data[EW_BITS-1:0];
                     early_enable_in  = req_write_data[EARLY_ENABLE_BIT];
                     down_counter_in  = reload_ff;
                  end
               end
               OFF_CLEAR: begin
                  if (rev_clear && req_write_data[FLAG_BIT_NEW]) begin
                     early_flag_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_READ: begin
            case (req_reg_offset)
               OFF_PRESC:   rsp_read_data_in = DATA_BITS'(prescale_code_ff);
               OFF_RELOAD:  rsp_read_data_in = DATA_BITS'(reload_ff);
               OFF_STATUS: begin
                  rsp_read_data_in[STATUS_RUN_BIT] = running_ff && rev_run;
                  if (early_flag_ff) begin
                     if (rev_clear) begin
                        rsp_read_data_in[FLAG_BIT_NEW] = 1'b1;
                     end else begin
                        rsp_read_data_in[FLAG_BIT_OLD] = 1'b1;
                     end
                  end
               end
               OFF_EARLY: begin
                  rsp_read_data_in = DATA_BITS'(early_compare_ff);
                  rsp_read_data_in[EARLY_ENABLE_BIT] = early_enable_ff;
               end
               OFF_VERSION: rsp_read_data_in = DATA_BITS'(revision_ff);
               default:     rsp_read_data_in = '0;
            endcase
         end
         OP_TICK: begin
            if (running_ff) begin
               if (count_next < divide) begin
                  prescale_count_in = count_next[PRESC_BITS-1:0];
               end else begin
                  prescale_count_in = '0;
                  if (down_counter_ff <= COUNTER_BITS'(1)) begin
                     if (early_compare_ff == '0) begin
                        early_flag_in = 1'b1;
                     end
                     down_counter_in      = reload_ff;
                     rsp_reset_request_in = 1'b1;
                  end else begin
                     down_counter_in = counter_dec;
                     if (counter_dec == COUNTER_BITS'(early_compare_ff)) begin
                        early_flag_in = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // unused operation code reports nothing
      rsp_early_irq_in = (req_operation != OP_NONE) && early_flag_in && early_enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         revision_ff       <= REV_RESET;
         down_counter_ff   <= '1;
         reload_ff         <= '1;
         prescale_code_ff  <= '0;
         prescale_count_ff <= '0;
         early_compare_ff  <= '0;
         early_enable_ff   <= 1'b0;
         early_flag_ff     <= 1'b0;
         unlocked_ff       <= 1'b0;
         running_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            revision_ff <= csr_write_data;
         end
         if (req_accept) begin
            down_counter_ff   <= down_counter_in;
            reload_ff         <= reload_in;
            prescale_code_ff  <= prescale_code_in;
            prescale_count_ff <= prescale_count_in;
            early_compare_ff  <= early_compare_in;
            early_enable_ff   <= early_enable_in;
            early_flag_ff     <= early_flag_in;
            unlocked_ff       <= unlocked_in;
            running_ff        <= running_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_read_data_ff     <= rsp_read_data_in;
         rsp_early_irq_ff     <= rsp_early_irq_in;
         rsp_reset_request_ff <= rsp_reset_request_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_early_irq     = rsp_early_irq_ff;
   assign rsp_reset_request = rsp_reset_request_ff;

   `IWDP_ASSERT_NEXT(a_irq_tracks_state, clock, reset,
      req_accept && (req_operation != OP_NONE),
      rsp_early_irq == (early_flag_ff && early_enable_ff))

   `IWDP_ASSERT_SAME(a_reset_pulse_running, clock, reset,
      rsp_valid_ff && rsp_reset_request,
      running_ff && (rsp_read_data == '0))

   `IWDP_ASSERT_NEXT(a_stopped_tick_idle, clock, reset,
      req_accept && (req_operation == OP_TICK) && !running_ff,
      $stable(down_counter_ff) && $stable(prescale_count_ff))

   `IWDP_ASSERT_NEXT(a_locked_reload, clock, reset,
      req_accept && (req_operation == OP_WRITE) && (req_reg_offset == OFF_RELOAD)
         && !unlocked_ff,
      $stable(reload_ff))

endmodule
